// ===== rtl/pkst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_pkg
// shared codes and types of the pair keyed state table
// ----------------------------------------------------------------------------
package pkst_pkg;

    localparam int ACTION_BITS = 3;
    localparam int STATUS_BITS = 2;
    localparam int STATE_BITS  = 2;

    typedef logic [ACTION_BITS-1:0] t_action;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [STATE_BITS-1:0]  t_code;

    localparam t_action ACT_SET       = 3'd0;
    localparam t_action ACT_QUERY     = 3'd1;
    localparam t_action ACT_RM_PLAYER = 3'd2;
    localparam t_action ACT_RM_ENTITY = 3'd3;
    localparam t_action ACT_CLEAR     = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_READY = 2'd1;
    localparam t_status ST_INVALID   = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    // result of comparing one stored record against the item keys
    typedef struct packed {
        logic used;
        logic pair_hit;
        logic player_hit;
        logic entity_hit;
    } t_cmp;

endpackage
`default_nettype wire

// ===== rtl/pkst_item_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_item_if
// request channel: one action with its keys and new state
// ----------------------------------------------------------------------------
interface pkst_item_if #(
    parameter int PLAYER_BITS = 8,
    parameter int ENTITY_BITS = 32
);
    logic                   valid;
    logic                   ready;
    pkst_pkg::t_action      action;
    logic [PLAYER_BITS-1:0] player_key;
    logic [ENTITY_BITS-1:0] entity_key;
    pkst_pkg::t_code        new_state;

    modport source (output valid, output action, output player_key,
                    output entity_key, output new_state, input ready);
    modport sink   (input valid, input action, input player_key,
                    input entity_key, input new_state, output ready);
endinterface
`default_nettype wire

// ===== rtl/pkst_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_res_if
// response channel: status, state read and record count
// ----------------------------------------------------------------------------
interface pkst_res_if #(
    parameter int COUNT_BITS = 7
);
    logic                  valid;
    logic                  ready;
    pkst_pkg::t_status     status;
    pkst_pkg::t_code       read_state;
    logic [COUNT_BITS-1:0] entry_count;

    modport source (output valid, output status, output read_state,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input read_state,
                    input entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/pkst_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_cfg_if
// configuration write channel for the enable register
// ----------------------------------------------------------------------------
interface pkst_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pkst_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_mem
// record store: one write port, one registered read port
// ----------------------------------------------------------------------------
module pkst_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 43,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pkst_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_cmp
// key compare unit shared by every slot of the scan
// ----------------------------------------------------------------------------
module pkst_cmp #(
    parameter int PLAYER_BITS = 8,
    parameter int ENTITY_BITS = 32
) (
    input  wire logic                   i_used,
    input  wire logic [PLAYER_BITS-1:0] i_rec_player,
    input  wire logic [ENTITY_BITS-1:0] i_rec_entity,
    input  wire logic [PLAYER_BITS-1:0] i_key_player,
    input  wire logic [ENTITY_BITS-1:0] i_key_entity,
    output pkst_pkg::t_cmp              o_cmp
);

    logic player_eq;
    logic entity_eq;

    assign player_eq        = (i_rec_player == i_key_player);
    assign entity_eq        = (i_rec_entity == i_key_entity);
    assign o_cmp.used       = i_used;
    assign o_cmp.player_hit = i_used && player_eq;
    assign o_cmp.entity_hit = i_used && entity_eq;
    assign o_cmp.pair_hit   = i_used && player_eq && entity_eq;

endmodule
`default_nettype wire

// ===== rtl/pair_keyed_state_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pair_keyed_state_table
// table of (player, entity) keyed records holding a small state code
// ----------------------------------------------------------------------------
// Set, query and the two removes each walk every slot of the record memory
// once, one slot per clock through its single read port and one key compare
// unit. Clear sweeps the memory one slot per cycle; an item rejected as not
// ready or invalid skips the walk. After reset the block runs a clearing
// pass over every slot before it takes its first item; configuration writes
// are taken at any time. One item is in work at a time; its result sits in
// an output register, so the next item may be accepted before the result is
// taken.
// ----------------------------------------------------------------------------
module pair_keyed_state_table #(
    parameter int TABLE_DEPTH   = 64,
    parameter int PLAYER_BITS   = 8,
    parameter int ENTITY_BITS   = 32,
    parameter int HIGHEST_STATE = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pkst_item_if.sink   i_item,
    pkst_res_if.source  o_res,
    pkst_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = AW + 1;
    localparam int CB = $clog2(TABLE_DEPTH + 1);
    localparam int SB = pkst_pkg::STATE_BITS;
    localparam int RW = 1 + PLAYER_BITS + ENTITY_BITS + SB;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLR    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // control
    logic [2:0]              r_state,     n_state;
    logic [IW-1:0]           r_idx,       n_idx;
    logic                    r_vld,       n_vld;
    logic                    r_found,     n_found;
    logic                    r_free,      n_free;
    logic [CB-1:0]           r_count,     n_count;
    logic                    r_enabled,   n_enabled;
    logic                    r_clr_item,  n_clr_item;
    logic                    r_out_valid, n_out_valid;
    // payload
    logic [AW-1:0]           r_chk_addr,   n_chk_addr;
    pkst_pkg::t_action       r_action,     n_action;
    logic [PLAYER_BITS-1:0]  r_player,     n_player;
    logic [ENTITY_BITS-1:0]  r_entity,     n_entity;
    pkst_pkg::t_code         r_ns,         n_ns;
    pkst_pkg::t_status       r_status,     n_status;
    logic [AW-1:0]           r_found_addr, n_found_addr;
    pkst_pkg::t_code         r_found_state, n_found_state;
    logic [AW-1:0]           r_free_addr,  n_free_addr;
    pkst_pkg::t_status       r_out_status, n_out_status;
    pkst_pkg::t_code         r_out_rd,     n_out_rd;
    logic [CB-1:0]           r_out_cnt,    n_out_cnt;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [RW-1:0]           mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic [RW-1:0]           mem_rdata;
    pkst_pkg::t_cmp          cmp;
    logic                    in_take;
    logic                    set_bad;
    logic                    pair_bad;

    pkst_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (RW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pkst_cmp #(
        .PLAYER_BITS (PLAYER_BITS),
        .ENTITY_BITS (ENTITY_BITS)
    ) u_cmp (
        .i_used       (mem_rdata[RW-1]),
        .i_rec_player (mem_rdata[RW-2 -: PLAYER_BITS]),
        .i_rec_entity (mem_rdata[SB +: ENTITY_BITS]),
        .i_key_player (r_player),
        .i_key_entity (r_entity),
        .o_cmp        (cmp)
    );

    assign i_item.ready      = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.read_state  = r_out_rd;
    assign o_res.entry_count = r_out_cnt;

    assign in_take  = i_item.valid && (r_state == S_IDLE);
    assign pair_bad = (i_item.player_key == '0) || (i_item.entity_key == '0);
    assign set_bad  = pair_bad || (i_item.new_state > SB'(HIGHEST_STATE));

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_vld         = 1'b0;
        n_found       = r_found;
        n_free        = r_free;
        n_count       = r_count;
        n_enabled     = i_cfg.valid ? i_cfg.data : r_enabled;
        n_clr_item    = r_clr_item;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_chk_addr    = r_chk_addr;
        n_action      = r_action;
        n_player      = r_player;
        n_entity      = r_entity;
        n_ns          = r_ns;
        n_status      = r_status;
        n_found_addr  = r_found_addr;
        n_found_state = r_found_state;
        n_free_addr   = r_free_addr;
        n_out_status  = r_out_status;
        n_out_rd      = r_out_rd;
        n_out_cnt     = r_out_cnt;
        mem_we        = 1'b0;
        mem_waddr     = r_chk_addr;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_action = i_item.action;
                    n_player = i_item.player_key;
                    n_entity = i_item.entity_key;
                    n_ns     = i_item.new_state;
                    n_found  = 1'b0;
                    n_free   = 1'b0;
                    n_idx    = '0;
                    n_status = pkst_pkg::ST_OK;
                    n_state  = S_SCAN;
                    if (!r_enabled) begin
                        n_status = pkst_pkg::ST_NOT_READY;
                        n_state  = S_DONE;
                    end else begin
                        case (i_item.action)
                            pkst_pkg::ACT_SET: begin
                                if (set_bad) begin
                                    n_status = pkst_pkg::ST_INVALID;
                                    n_state  = S_DONE;
                                end
                            end
                            pkst_pkg::ACT_QUERY: begin
                                if (pair_bad) begin
                                    n_status = pkst_pkg::ST_INVALID;
                                    n_state  = S_DONE;
                                end
                            end
                            pkst_pkg::ACT_RM_PLAYER: begin
                                if (i_item.player_key == '0) begin
                                    n_status = pkst_pkg::ST_INVALID;
                                    n_state  = S_DONE;
                                end
                            end
                            pkst_pkg::ACT_RM_ENTITY: begin
                                if (i_item.entity_key == '0) begin
                                    n_status = pkst_pkg::ST_INVALID;
                                    n_state  = S_DONE;
                                end
                            end
                            pkst_pkg::ACT_CLEAR: begin
                                n_clr_item = 1'b1;
                                n_state    = S_CLR;
                            end
                            default: begin
                                n_status = pkst_pkg::ST_INVALID;
                                n_state  = S_DONE;
                            end
                        endcase
                    end
                end
            end
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                n_idx     = r_idx + IW'(1);
                if (r_idx == IW'(TABLE_DEPTH - 1)) begin
                    n_count    = '0;
                    n_clr_item = 1'b0;
                    n_state    = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_SCAN: begin
                // read one slot ahead, compare the slot read last cycle
                mem_re     = (r_idx != IW'(TABLE_DEPTH));
                n_vld      = mem_re;
                n_chk_addr = r_idx[AW-1:0];
                if (mem_re) begin
                    n_idx = r_idx + IW'(1);
                end else begin
                    n_state = S_COMMIT;
                end
                if (r_vld) begin
                    case (r_action)
                        pkst_pkg::ACT_SET, pkst_pkg::ACT_QUERY: begin
                            if (cmp.pair_hit && !r_found) begin
                                n_found       = 1'b1;
                                n_found_addr  = r_chk_addr;
                                n_found_state = mem_rdata[SB-1:0];
                            end
                            if (!cmp.used && !r_free) begin
                                n_free      = 1'b1;
                                n_free_addr = r_chk_addr;
                            end
                        end
                        pkst_pkg::ACT_RM_PLAYER: begin
                            if (cmp.player_hit) begin
                                mem_we    = 1'b1;
                                mem_wdata = {1'b0, mem_rdata[RW-2:0]};
                                n_count   = r_count - CB'(1);
                            end
                        end
                        pkst_pkg::ACT_RM_ENTITY: begin
                            if (cmp.entity_hit) begin
                                mem_we    = 1'b1;
                                mem_wdata = {1'b0, mem_rdata[RW-2:0]};
                                n_count   = r_count - CB'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COMMIT: begin
                n_state = S_DONE;
                if (r_action == pkst_pkg::ACT_SET) begin
                    mem_wdata = {1'b1, r_player, r_entity, r_ns};
                    if (r_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_found_addr;
                    end else if (r_free) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_free_addr;
                        n_count   = r_count + CB'(1);
                    end else begin
                        n_status = pkst_pkg::ST_FULL;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_cnt    = r_count;
                    n_out_rd     = '0;
                    if (r_action == pkst_pkg::ACT_QUERY && r_found &&
                        r_status == pkst_pkg::ST_OK) begin
                        n_out_rd = r_found_state;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_vld       <= 1'b0;
            r_found     <= 1'b0;
            r_free      <= 1'b0;
            r_count     <= '0;
            r_enabled   <= 1'b1;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_vld       <= n_vld;
            r_found     <= n_found;
            r_free      <= n_free;
            r_count     <= n_count;
            r_enabled   <= n_enabled;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr    <= n_chk_addr;
        r_action      <= n_action;
        r_player      <= n_player;
        r_entity      <= n_entity;
        r_ns          <= n_ns;
        r_status      <= n_status;
        r_found_addr  <= n_found_addr;
        r_found_state <= n_found_state;
        r_free_addr   <= n_free_addr;
        r_out_status  <= n_out_status;
        r_out_rd      <= n_out_rd;
        r_out_cnt     <= n_out_cnt;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(TABLE_DEPTH))
        else $error("record count above table depth");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done step");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ($past(r_state) == S_SCAN ||
                               $past(r_state) == S_COMMIT ||
                               $past(r_state) == S_CLR))
        else $error("record count changed outside scan, commit or clear");

    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && mem_we) |-> r_vld)
        else $error("slot removed without a compared read");

endmodule
`default_nettype wire

// ===== verif/pkst_reply_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_reply_checker
// watches the item, reply and enable channels of the pair keyed state table,
// keeps its own copy of the record table, works out the reply of every
// accepted item and compares it, in order, with the replies taken from the
// block
// ----------------------------------------------------------------------------
module pkst_reply_checker
    import pkst_pkg::*;
#(
    parameter int TABLE_DEPTH   = 64,
    parameter int PLAYER_BITS   = 8,
    parameter int ENTITY_BITS   = 32,
    parameter int HIGHEST_STATE = 2,
    parameter int COUNT_BITS    = 7
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pkst_item_if      i_item,
    pkst_res_if       i_res,
    pkst_cfg_if       i_cfg,
    output int        o_pending,
    output int        o_fail_count
);

    typedef struct packed {
        t_status               status;
        t_code                 read_state;
        logic [COUNT_BITS-1:0] entry_count;
    } t_reply;

    // record table as the block should hold it
    logic [TABLE_DEPTH-1:0] rec_used;
    logic [PLAYER_BITS-1:0] rec_player [TABLE_DEPTH];
    logic [ENTITY_BITS-1:0] rec_entity [TABLE_DEPTH];
    t_code                  rec_state  [TABLE_DEPTH];
    int                     rec_count;
    logic                   enabled;

    t_reply                 replies_due [$];
    int                     fail_total = 0;

    function automatic int find_pair(logic [PLAYER_BITS-1:0] p,
                                     logic [ENTITY_BITS-1:0] e);
        int hit;
        hit = -1;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (rec_used[k] && rec_player[k] == p && rec_entity[k] == e) begin
                hit = k;
            end
        end
        return hit;
    endfunction

    // carries out one action on the table copy and returns its reply
    function automatic t_reply apply_action(t_action act,
                                            logic [PLAYER_BITS-1:0] p,
                                            logic [ENTITY_BITS-1:0] e,
                                            t_code ns);
        t_reply r;
        int     hit;
        int     slot;
        r = '0;
        r.status = ST_OK;
        slot = -1;
        if (!enabled) begin
            r.status = ST_NOT_READY;
        end else begin
            case (act)
                ACT_SET: begin
                    if (p == '0 || e == '0 || ns > HIGHEST_STATE) begin
                        r.status = ST_INVALID;
                    end else begin
                        hit = find_pair(p, e);
                        if (hit >= 0) begin
                            rec_state[hit] = ns;
                        end else begin
                            // lowest free slot takes the new record
                            for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
                                if (!rec_used[k]) slot = k;
                            end
                            if (slot < 0) begin
                                r.status = ST_FULL;
                            end else begin
                                rec_used[slot]   = 1'b1;
                                rec_player[slot] = p;
                                rec_entity[slot] = e;
                                rec_state[slot]  = ns;
                                rec_count++;
                            end
                        end
                    end
                end
                ACT_QUERY: begin
                    if (p == '0 || e == '0) begin
                        r.status = ST_INVALID;
                    end else begin
                        hit = find_pair(p, e);
                        if (hit >= 0) r.read_state = rec_state[hit];
                    end
                end
                ACT_RM_PLAYER: begin
                    if (p == '0) begin
                        r.status = ST_INVALID;
                    end else begin
                        for (int k = 0; k < TABLE_DEPTH; k++) begin
                            if (rec_used[k] && rec_player[k] == p) begin
                                rec_used[k] = 1'b0;
                                rec_count--;
                            end
                        end
                    end
                end
                ACT_RM_ENTITY: begin
                    if (e == '0) begin
                        r.status = ST_INVALID;
                    end else begin
                        for (int k = 0; k < TABLE_DEPTH; k++) begin
                            if (rec_used[k] && rec_entity[k] == e) begin
                                rec_used[k] = 1'b0;
                                rec_count--;
                            end
                        end
                    end
                end
                ACT_CLEAR: begin
                    rec_used  = '0;
                    rec_count = 0;
                end
                default: begin
                    r.status = ST_INVALID;
                end
            endcase
        end
        r.entry_count = rec_count[COUNT_BITS-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            rec_used  = '0;
            rec_count = 0;
            enabled   = 1'b1;
            replies_due.delete();
        end else begin
            // a reply always belongs to an item taken at an earlier edge
            if (i_res.valid && i_res.ready) begin
                got.status      = i_res.status;
                got.read_state  = i_res.read_state;
                got.entry_count = i_res.entry_count;
                if (replies_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: reply with no item outstanding, expected no reply,",
                             $time, " got status %0d state %0d count %0d",
                             got.status, got.read_state, got.entry_count);
                end else begin
                    want = replies_due.pop_front();
                    if (got != want) begin
                        fail_total++;
                        $display("%0t: reply mismatch, expected status %0d state %0d",
                                 $time, want.status, want.read_state,
                                 " count %0d, got status %0d state %0d count %0d",
                                 want.entry_count, got.status, got.read_state,
                                 got.entry_count);
                    end
                end
            end
            // an item taken at the same edge as an enable write sees the old value
            if (i_item.valid && i_item.ready) begin
                replies_due.insert(replies_due.size(),
                                   apply_action(i_item.action, i_item.player_key,
                                                i_item.entity_key, i_item.new_state));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                enabled = i_cfg.data;
            end
        end
        o_pending    <= replies_due.size();
        o_fail_count <= fail_total;
    end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// stimulus for the pair keyed state table: directed corner items, then
// random mixes of set, query, remove and clear over small key pools so that
// records match, collide and fill the table, with the enable register
// switched off and on between phases; a separate checker judges every reply
// ----------------------------------------------------------------------------
module testbench;
    import pkst_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int PLAYER_BITS   = 8;
    localparam int ENTITY_BITS   = 32;
    localparam int HIGHEST_STATE = 2;
    localparam int COUNT_BITS    = 7;
    localparam int ENT_POOL_SIZE = 12;
    localparam int PLAYER_POOL   = 6;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 5000;

    logic clk = 1'b0;
    logic rst_n;
    int   pending;
    int   fail_count;
    int   idle_cycles = 0;
    bit   calm = 1'b0;
    bit   hold_go = 1'b0;

    logic [ENTITY_BITS-1:0] ent_pool [ENT_POOL_SIZE];

    pkst_item_if #(.PLAYER_BITS(PLAYER_BITS), .ENTITY_BITS(ENTITY_BITS)) item_ch ();
    pkst_res_if  #(.COUNT_BITS(COUNT_BITS)) res_ch ();
    pkst_cfg_if  cfg_ch ();

    pair_keyed_state_table #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .PLAYER_BITS   (PLAYER_BITS),
        .ENTITY_BITS   (ENTITY_BITS),
        .HIGHEST_STATE (HIGHEST_STATE)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    pkst_reply_checker #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .PLAYER_BITS   (PLAYER_BITS),
        .ENTITY_BITS   (ENTITY_BITS),
        .HIGHEST_STATE (HIGHEST_STATE),
        .COUNT_BITS    (COUNT_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #6 clk = ~clk;

    // stall watchdog: any handshake on any channel counts as progress
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // reply side: random stalls, plus one long hold-off to back the block up
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    function automatic logic [PLAYER_BITS-1:0] pick_player();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 15) return PLAYER_BITS'($urandom());
        return PLAYER_BITS'($urandom_range(1, PLAYER_POOL));
    endfunction

    function automatic logic [ENTITY_BITS-1:0] pick_entity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 15) return ENTITY_BITS'($urandom());
        return ent_pool[$urandom_range(0, ENT_POOL_SIZE - 1)];
    endfunction

    // valid stays high from one item to the next unless a gap is drawn
    task automatic push_item(t_action act, logic [PLAYER_BITS-1:0] p,
                             logic [ENTITY_BITS-1:0] e, t_code ns);
        while (!calm && $urandom_range(0, 99) < 33) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.player_key <= p;
        item_ch.entity_key <= e;
        item_ch.new_state  <= ns;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_enable(logic value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_items(int n, int pct_set, int pct_query);
        int                     r;
        t_action                act;
        logic [PLAYER_BITS-1:0] p;
        logic [ENTITY_BITS-1:0] e;
        t_code                  ns;
        repeat (n) begin
            r  = $urandom_range(0, 99);
            p  = pick_player();
            e  = pick_entity();
            ns = t_code'($urandom_range(0, HIGHEST_STATE));
            if (r < 3) begin
                // noise: any code, any keys, any state
                act = t_action'($urandom());
                p   = PLAYER_BITS'($urandom());
                e   = ENTITY_BITS'($urandom());
                ns  = t_code'($urandom());
            end else if (r < 3 + pct_set) begin
                act = ACT_SET;
                if ($urandom_range(0, 11) == 0) ns = t_code'(HIGHEST_STATE + 1);
            end else if (r < 3 + pct_set + pct_query) begin
                act = ACT_QUERY;
            end else if (r == 99) begin
                act = ACT_CLEAR;
            end else begin
                act = r[0] ? ACT_RM_PLAYER : ACT_RM_ENTITY;
            end
            push_item(act, p, e, ns);
        end
    endtask

    initial begin
        int k;
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.action     <= ACT_SET;
        item_ch.player_key <= '0;
        item_ch.entity_key <= '0;
        item_ch.new_state  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= 1'b0;
        for (k = 0; k < ENT_POOL_SIZE; k++) begin
            ent_pool[k] = (k < ENT_POOL_SIZE / 2) ? ENTITY_BITS'(k + 1)
                                                  : ENTITY_BITS'($urandom());
            if (ent_pool[k] == '0) ent_pool[k] = ENTITY_BITS'(k + 1);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_enable(1'b1);

        // corner items
        push_item(ACT_QUERY, 8'd1, 32'd1, 2'd0);
        push_item(ACT_SET, 8'd0, 32'd5, 2'd1);
        push_item(ACT_SET, 8'd1, 32'd0, 2'd1);
        push_item(ACT_SET, 8'd1, 32'd1, t_code'(HIGHEST_STATE + 1));
        push_item(ACT_SET, 8'hff, 32'hffff_ffff, t_code'(HIGHEST_STATE));
        push_item(ACT_SET, 8'd1, 32'd1, 2'd1);
        push_item(ACT_SET, 8'd1, 32'd1, 2'd0);
        push_item(ACT_QUERY, 8'hff, 32'hffff_ffff, 2'd0);
        push_item(ACT_QUERY, 8'd1, 32'd1, 2'd3);
        push_item(ACT_QUERY, 8'd0, 32'd1, 2'd0);
        push_item(ACT_QUERY, 8'd1, 32'd0, 2'd0);
        push_item(ACT_RM_PLAYER, 8'd0, 32'd1, 2'd0);
        push_item(ACT_RM_ENTITY, 8'd1, 32'd0, 2'd0);
        push_item(ACT_SET, 8'd1, 32'h8000_0000, 2'd2);
        push_item(ACT_RM_PLAYER, 8'd1, 32'd0, 2'd0);
        push_item(ACT_QUERY, 8'd1, 32'h8000_0000, 2'd0);
        push_item(ACT_RM_ENTITY, 8'd0, 32'hffff_ffff, 2'd0);
        push_item(t_action'(ACT_CLEAR + 1), 8'd1, 32'd1, 2'd1);
        push_item(t_action'(ACT_CLEAR + 2), 8'd1, 32'd1, 2'd1);
        push_item(t_action'(ACT_CLEAR + 3), 8'd1, 32'd1, 2'd1);
        push_item(ACT_SET, 8'd5, 32'd5, 2'd2);
        push_item(ACT_CLEAR, 8'd0, 32'd0, 2'd0);
        push_item(ACT_SET, 8'h55, 32'haaaa_aaaa, 2'd1);

        // back-to-back stretch, with the reply side held off at its start
        calm    = 1'b1;
        hold_go = 1'b1;
        random_items(120, 55, 30);
        calm = 1'b0;
        random_items(180, 55, 30);

        wait_drained();
        write_enable(1'b0);
        random_items(40, 55, 30);
        wait_drained();
        write_enable(1'b1);

        // fill every slot, then hit the full case and work on a full table
        push_item(ACT_CLEAR, 8'd0, 32'd0, 2'd0);
        for (k = 0; k < TABLE_DEPTH; k++) begin
            push_item(ACT_SET, PLAYER_BITS'(k + 1), ent_pool[k % ENT_POOL_SIZE],
                      t_code'(k % (HIGHEST_STATE + 1)));
        end
        push_item(ACT_SET, 8'd200, ent_pool[0], 2'd1);
        push_item(ACT_SET, 8'd1, ent_pool[0], 2'd2);
        push_item(ACT_QUERY, PLAYER_BITS'(TABLE_DEPTH),
                  ent_pool[(TABLE_DEPTH - 1) % ENT_POOL_SIZE], 2'd0);
        push_item(ACT_RM_ENTITY, 8'd0, ent_pool[0], 2'd0);
        push_item(ACT_SET, 8'd200, ent_pool[0], 2'd1);

        // set-heavy mix keeps the table near full
        random_items(300, 80, 12);

        wait_drained();
        write_enable(1'b0);
        random_items(20, 55, 30);
        wait_drained();
        write_enable(1'b1);
        random_items(200, 55, 30);

        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
